[hdl/sft_pkg.sv]
// Shared types, codes and helpers for the SMT fetch thread arbiter.
// Used by the order and count cells, the top level and the testbench; depends on nothing.
package sft_pkg;

  localparam int MAX_THREADS_DEF = 4;
  localparam int COUNT_BITS_DEF  = 8;
  localparam int OCC_W           = 8;
  localparam int TID_W           = 2;
  localparam int MASK_W          = 4;

  // Command codes carried in s_tuser.
  localparam logic [1:0] FUNC_SELECT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_APPEND = 2'd2;

  // Policy register codes.
  localparam logic [1:0] POL_RR   = 2'd0;
  localparam logic [1:0] POL_IQ   = 2'd1;
  localparam logic [1:0] POL_LSQ  = 2'd2;
  localparam logic [1:0] POL_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic REG_THREAD_COUNT = 1'b0;
  localparam logic REG_POLICY       = 1'b1;

  // Fetch status and cache state codes of thread 0.
  localparam logic [1:0] ST_BLOCKED  = 2'd1;
  localparam logic [1:0] ST_SQUASH   = 2'd2;
  localparam logic [1:0] ST_TRAP     = 2'd3;
  localparam logic [2:0] CS_WAIT_RSP = 3'd1;
  localparam logic [2:0] CS_TLB_WAIT = 3'd2;
  localparam logic [2:0] CS_RETRY    = 3'd3;
  localparam logic [2:0] CS_FAILED   = 3'd4;

  // Stall reason codes.
  localparam logic [3:0] STALL_NONE       = 4'd0;
  localparam logic [3:0] STALL_DRAIN      = 4'd1;
  localparam logic [3:0] STALL_NO_ACTIVE  = 4'd2;
  localparam logic [3:0] STALL_BLOCKED    = 4'd3;
  localparam logic [3:0] STALL_SQUASH     = 4'd4;
  localparam logic [3:0] STALL_ICACHE     = 4'd5;
  localparam logic [3:0] STALL_TLB        = 4'd6;
  localparam logic [3:0] STALL_TRAP       = 4'd7;
  localparam logic [3:0] STALL_RETRY      = 4'd8;
  localparam logic [3:0] STALL_FAILED     = 4'd9;
  localparam logic [3:0] STALL_UNEXPECTED = 4'd10;

  // How the order cells update on an accepted beat.
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_SHIFT_GRANT,
    UPD_SHIFT,
    UPD_APPEND
  } sft_upd_t;

  // Match key broadcast to every order cell.
  typedef struct packed {
    logic              by_elig;
    logic [TID_W-1:0]  tid;
    logic [MASK_W-1:0] elig;
  } sft_match_t;

  function automatic logic [3:0] classify_stall(input logic [MASK_W-1:0] active,
                                                input logic drain,
                                                input logic [1:0] status,
                                                input logic [2:0] cache);
    logic [3:0] r;
    if (drain)                    r = STALL_DRAIN;
    else if (active == '0)        r = STALL_NO_ACTIVE;
    else if (status == ST_BLOCKED) r = STALL_BLOCKED;
    else if (status == ST_SQUASH) r = STALL_SQUASH;
    else if (cache == CS_WAIT_RSP) r = STALL_ICACHE;
    else if (cache == CS_TLB_WAIT) r = STALL_TLB;
    else if (status == ST_TRAP)   r = STALL_TRAP;
    else if (cache == CS_RETRY)   r = STALL_RETRY;
    else if (cache == CS_FAILED)  r = STALL_FAILED;
    else                          r = STALL_UNEXPECTED;
    return r;
  endfunction

endpackage

[hdl/sft_order_cell.sv]
// One slot of the round-robin priority order.
// Passes the first-match flag and matched thread to the next slot; uses sft_pkg.
module sft_order_cell #(
  parameter int MAX_THREADS = sft_pkg::MAX_THREADS_DEF,
  parameter int CELL_ID     = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  sft_pkg::sft_upd_t                    upd,
  input  sft_pkg::sft_match_t                  key,
  input  logic [$clog2(MAX_THREADS+1)-1:0]     length,
  input  logic [sft_pkg::TID_W-1:0]            next_entry,
  input  logic                                 found_in,
  input  logic [sft_pkg::TID_W-1:0]            sel_in,
  output logic                                 found_out,
  output logic [sft_pkg::TID_W-1:0]            sel_out,
  output logic [sft_pkg::TID_W-1:0]            entry
);
  import sft_pkg::*;

  localparam int LEN_W       = $clog2(MAX_THREADS + 1);
  localparam int MaskThreads = (MAX_THREADS < 4) ? MAX_THREADS : 4;

  logic valid;
  logic last;
  logic hit;
  logic found_here;

  assign valid = LEN_W'(CELL_ID) < length;
  assign last  = LEN_W'(CELL_ID + 1) == length;

  // Round robin matches on the eligible bit of the stored thread; the edit
  // commands match on the thread number itself.
  assign hit = valid && (key.by_elig ?
                         (({1'b0, entry} < 3'(MaskThreads)) && key.elig[entry]) :
                         (entry == key.tid));

  assign found_here = found_in || hit;
  assign found_out  = found_here;
  assign sel_out    = found_in ? sel_in : entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= TID_W'(CELL_ID & 3);
    end else if (accept) begin
      case (upd)
        UPD_SHIFT_GRANT: begin
          if (found_here && valid) entry <= last ? sel_out : next_entry;
        end
        UPD_SHIFT: begin
          if (found_here && valid && !last) entry <= next_entry;
        end
        UPD_APPEND: begin
          if (LEN_W'(CELL_ID) == length) entry <= key.tid;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/sft_count_cell.sv]
// One thread's stage of the lowest-occupancy search chain.
// Hands the best count so far and its thread to the next stage; uses sft_pkg.
module sft_count_cell #(
  parameter int COUNT_W = sft_pkg::COUNT_BITS_DEF,
  parameter int CELL_ID = 0
) (
  input  logic                          cand,
  input  logic [COUNT_W-1:0]            cnt,
  input  logic                          found_in,
  input  logic [COUNT_W-1:0]            best_in,
  input  logic [sft_pkg::TID_W-1:0]     tid_in,
  output logic                          found_out,
  output logic [COUNT_W-1:0]            best_out,
  output logic [sft_pkg::TID_W-1:0]     tid_out
);
  import sft_pkg::*;

  logic take;

  // Strict compare keeps ties with the lower thread further up the chain.
  assign take      = cand && (!found_in || (cnt < best_in));
  assign found_out = found_in || cand;
  assign best_out  = take ? cnt : best_in;
  assign tid_out   = take ? TID_W'(CELL_ID) : tid_in;

endmodule

[hdl/smt_fetch_thread_arbiter_core.sv]
// SMT fetch thread arbiter: picks the fetching thread or edits the priority order.
// The result of an accepted input beat is registered and shown on m_tdata in the next cycle.
// Throughput: one beat per cycle; s_tready = !m_tvalid || m_tready, set by the
// single output register, and the order cells update in the accepting cycle.
// Reset (rst, synchronous): order holds 0,1,2,... with length zero, thread_count 1,
// policy round robin, no result pending. Uses sft_pkg, sft_order_cell, sft_count_cell.
module smt_fetch_thread_arbiter_core #(
  parameter int MAX_THREADS = sft_pkg::MAX_THREADS_DEF,
  parameter int COUNT_BITS  = sft_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [2:0]  wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, low bit up: thread_id[1:0], active_mask[5:2], eligible_mask[9:6],
  // occupancy_0[17:10], occupancy_1[25:18], occupancy_2[33:26],
  // occupancy_3[41:34], drain_first[42], status_first[44:43],
  // cache_state_first[47:45]
  input  logic [47:0] s_tdata,
  // s_tuser: func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, low bit up: grant_valid[0], grant_thread[2:1], stall_reason[6:3],
  // zero pad[7]
  output logic [7:0]  m_tdata
);
  import sft_pkg::*;

  localparam int LEN_W       = $clog2(MAX_THREADS + 1);
  localparam int MaskThreads = (MAX_THREADS < 4) ? MAX_THREADS : 4;
  localparam int COUNT_W     = (COUNT_BITS < OCC_W) ? COUNT_BITS : OCC_W;

  logic [1:0]        func;
  logic [TID_W-1:0]  thread_id;
  logic [MASK_W-1:0] active_mask;
  logic [MASK_W-1:0] eligible_mask;
  logic [OCC_W-1:0]  occ [4];
  logic              drain_first;
  logic [1:0]        status_first;
  logic [2:0]        cache_state_first;

  assign func              = s_tuser;
  assign thread_id         = s_tdata[1:0];
  assign active_mask       = s_tdata[5:2];
  assign eligible_mask     = s_tdata[9:6];
  assign occ[0]            = s_tdata[17:10];
  assign occ[1]            = s_tdata[25:18];
  assign occ[2]            = s_tdata[33:26];
  assign occ[3]            = s_tdata[41:34];
  assign drain_first       = s_tdata[42];
  assign status_first      = s_tdata[44:43];
  assign cache_state_first = s_tdata[47:45];

  logic [2:0]       thread_count;
  logic [1:0]       policy;
  logic [LEN_W-1:0] order_length;
  logic             accept;
  logic             multi;

  logic             out_grant;
  logic [TID_W-1:0] out_thread;
  logic [3:0]       out_stall;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign multi    = thread_count > 3'd1;
  assign m_tdata  = {1'b0, out_stall, out_thread, out_grant};

  always_ff @(posedge clk) begin
    if (rst) begin
      thread_count <= 3'd1;
      policy       <= POL_RR;
    end else if (wr_en) begin
      case (wr_index)
        REG_THREAD_COUNT: thread_count <= wr_data;
        REG_POLICY:       policy       <= wr_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Priority order chain.
  sft_match_t       key;
  sft_upd_t         upd;
  logic             found [MAX_THREADS+1];
  logic [TID_W-1:0] sel   [MAX_THREADS+1];
  logic [TID_W-1:0] entry [MAX_THREADS];
  logic             append_ok;

  assign key.by_elig = (func == FUNC_SELECT);
  assign key.tid     = thread_id;
  assign key.elig    = eligible_mask;
  assign found[0]    = 1'b0;
  assign sel[0]      = '0;

  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_order
    logic [TID_W-1:0] nxt;
    if (i + 1 < MAX_THREADS) begin : g_mid
      assign nxt = entry[i+1];
    end else begin : g_end
      assign nxt = entry[i];
    end
    sft_order_cell #(
      .MAX_THREADS(MAX_THREADS),
      .CELL_ID    (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .upd       (upd),
      .key       (key),
      .length    (order_length),
      .next_entry(nxt),
      .found_in  (found[i]),
      .sel_in    (sel[i]),
      .found_out (found[i+1]),
      .sel_out   (sel[i+1]),
      .entry     (entry[i])
    );
  end

  assign append_ok = (int'(thread_id) < MAX_THREADS) &&
                     (order_length < LEN_W'(MAX_THREADS)) && !found[MAX_THREADS];

  always_comb begin
    upd = UPD_NONE;
    case (func)
      FUNC_SELECT: if (multi && policy == POL_RR) upd = UPD_SHIFT_GRANT;
      FUNC_REMOVE: upd = UPD_SHIFT;
      FUNC_APPEND: if (append_ok) upd = UPD_APPEND;
      default:     upd = UPD_NONE;
    endcase
  end

  // Lowest-occupancy chain.
  logic               cfound [MaskThreads+1];
  logic [COUNT_W-1:0] cbest  [MaskThreads+1];
  logic [TID_W-1:0]   ctid   [MaskThreads+1];

  assign cfound[0] = 1'b0;
  assign cbest[0]  = '0;
  assign ctid[0]   = '0;

  for (genvar t = 0; t < MaskThreads; t++) begin : g_count
    sft_count_cell #(
      .COUNT_W(COUNT_W),
      .CELL_ID(t)
    ) u_cell (
      .cand     (active_mask[t] && eligible_mask[t]),
      .cnt      (occ[t][COUNT_W-1:0]),
      .found_in (cfound[t]),
      .best_in  (cbest[t]),
      .tid_in   (ctid[t]),
      .found_out(cfound[t+1]),
      .best_out (cbest[t+1]),
      .tid_out  (ctid[t+1])
    );
  end

  // Single-thread pick: the first active thread, if it is eligible.
  logic             st_found;
  logic             st_ok;
  logic [TID_W-1:0] st_tid;

  always_comb begin
    st_found = 1'b0;
    st_ok    = 1'b0;
    st_tid   = '0;
    for (int t = 0; t < MaskThreads; t++) begin
      if (!st_found && active_mask[t]) begin
        st_found = 1'b1;
        st_ok    = eligible_mask[t];
        st_tid   = TID_W'(t);
      end
    end
  end

  logic             res_ok;
  logic [TID_W-1:0] res_tid;
  logic [3:0]       res_stall;

  always_comb begin
    res_ok    = 1'b0;
    res_tid   = '0;
    res_stall = STALL_NONE;
    if (func == FUNC_SELECT) begin
      if (multi) begin
        case (policy)
          POL_RR: begin
            res_ok  = found[MAX_THREADS];
            res_tid = sel[MAX_THREADS];
          end
          POL_IQ, POL_LSQ: begin
            res_ok  = cfound[MaskThreads];
            res_tid = ctid[MaskThreads];
          end
          default: res_ok = 1'b0;
        endcase
      end else begin
        res_ok  = st_ok;
        res_tid = st_tid;
        if (!st_ok) begin
          res_stall = classify_stall(active_mask, drain_first, status_first,
                                     cache_state_first);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_length <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (accept) begin
        m_tvalid <= 1'b1;
        if (func == FUNC_REMOVE && found[MAX_THREADS]) begin
          order_length <= order_length - LEN_W'(1);
        end else if (func == FUNC_APPEND && append_ok) begin
          order_length <= order_length + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_grant  <= res_ok;
      out_thread <= res_ok ? res_tid : '0;
      out_stall  <= res_stall;
    end
  end

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    order_length <= LEN_W'(MAX_THREADS))
    else $error("order length beyond thread limit");

  a_grant_no_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_grant |-> out_stall == STALL_NONE)
    else $error("grant reported together with a stall reason");

  a_edit_no_grant: assert property (@(posedge clk) disable iff (rst)
    accept && func != FUNC_SELECT |=> m_tvalid && !out_grant && out_stall == STALL_NONE)
    else $error("edit command produced a grant or stall");

  a_remove_len: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_REMOVE && found[MAX_THREADS] |=>
      order_length == $past(order_length) - LEN_W'(1))
    else $error("remove of a listed thread did not shorten the order");
`endif

endmodule

[dv/tb_smt_fetch_thread_arbiter_core.sv]
// Testbench for smt_fetch_thread_arbiter_core: directed and random stream traffic checked
// against an in-bench model of thread selection, order edits and stall classification.
// Depends on sft_pkg and the arbiter RTL only.
`timescale 1ns / 100ps

module tb_smt_fetch_thread_arbiter_core;
  import sft_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 125;

  // One input beat, packed as on s_tdata (the last field sits in the lowest bits).
  typedef struct packed {
    logic [2:0]      cache;
    logic [1:0]      status;
    logic            drain;
    logic [3:0][7:0] occ;
    logic [3:0]      elig;
    logic [3:0]      active;
    logic [1:0]      tid;
  } fetch_req_t;

  // One result beat, packed as on m_tdata.
  typedef struct packed {
    logic       pad;
    logic [3:0] stall;
    logic [1:0] thread;
    logic       valid;
  } fetch_grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic        wr_index = 1'b0;
  logic [2:0]  wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  // Model state: priority order, its length and the two registers.
  logic [1:0]   rr_order [4];
  int           rr_len;
  logic [2:0]   cfg_threads;
  logic [1:0]   cfg_policy;

  fetch_grant_t pending_grants [$];
  fetch_grant_t want_grant;
  fetch_grant_t seen_grant;
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  bit           src_idle_on = 1'b1;
  bit           snk_idle_on = 1'b1;

  smt_fetch_thread_arbiter_core uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  function automatic logic [3:0] stall_cause(input fetch_req_t req);
    if (req.drain) return STALL_DRAIN;
    if (req.active == 4'b0000) return STALL_NO_ACTIVE;
    if (req.status == ST_BLOCKED) return STALL_BLOCKED;
    if (req.status == ST_SQUASH) return STALL_SQUASH;
    if (req.cache == CS_WAIT_RSP) return STALL_ICACHE;
    if (req.cache == CS_TLB_WAIT) return STALL_TLB;
    if (req.status == ST_TRAP) return STALL_TRAP;
    if (req.cache == CS_RETRY) return STALL_RETRY;
    if (req.cache == CS_FAILED) return STALL_FAILED;
    return STALL_UNEXPECTED;
  endfunction

  // Applies one accepted beat to the model state and returns the grant it produces.
  function automatic fetch_grant_t predict_fetch_grant(input logic [1:0] func,
                                                       input fetch_req_t req);
    fetch_grant_t g;
    bit           hit;
    logic [7:0]   best;
    logic [1:0]   t;
    int           i, j;
    g = '0;
    hit = 1'b0;
    best = '0;
    case (func)
      FUNC_REMOVE: begin
        for (i = 0; i < rr_len; i++) begin
          if (!hit && rr_order[i] == req.tid) begin
            for (j = i; j + 1 < rr_len; j++) rr_order[j] = rr_order[j + 1];
            hit = 1'b1;
          end
        end
        if (hit) rr_len--;
      end
      FUNC_APPEND: begin
        for (i = 0; i < rr_len; i++) if (rr_order[i] == req.tid) hit = 1'b1;
        if (!hit && rr_len < 4) begin
          rr_order[rr_len] = req.tid;
          rr_len++;
        end
      end
      FUNC_SELECT: begin
        if (cfg_threads > 3'd1) begin
          if (cfg_policy == POL_RR) begin
            for (i = 0; i < rr_len; i++) begin
              if (!g.valid && req.elig[rr_order[i]]) begin
                t = rr_order[i];
                for (j = i; j + 1 < rr_len; j++) rr_order[j] = rr_order[j + 1];
                rr_order[rr_len - 1] = t;
                g.valid = 1'b1;
                g.thread = t;
              end
            end
          end else if (cfg_policy == POL_IQ || cfg_policy == POL_LSQ) begin
            for (i = 0; i < 4; i++) begin
              if (req.active[i] && req.elig[i] && (!g.valid || req.occ[i] < best)) begin
                g.valid = 1'b1;
                g.thread = 2'(i);
                best = req.occ[i];
              end
            end
          end
        end else begin
          // Single-thread mode: only the lowest active thread may win.
          for (i = 0; i < 4; i++) begin
            if (!hit && req.active[i]) begin
              hit = 1'b1;
              if (req.elig[i]) begin
                g.valid = 1'b1;
                g.thread = 2'(i);
              end
            end
          end
          if (!g.valid) g.stall = stall_cause(req);
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic fetch_req_t make_req(input logic [1:0] tid, input logic [3:0] active,
                                          input logic [3:0] elig, input logic [31:0] occ,
                                          input logic drain, input logic [1:0] status,
                                          input logic [2:0] cache);
    fetch_req_t r;
    r.tid = tid;
    r.active = active;
    r.elig = elig;
    r.occ = occ;
    r.drain = drain;
    r.status = status;
    r.cache = cache;
    return r;
  endfunction

  function automatic void check_field(input string label, input int want, input int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, seen);
      mismatch_count++;
    end
  endfunction

  task automatic send_beat(input logic [1:0] func, input fetch_req_t req);
    while (src_idle_on && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_grants = {pending_grants, predict_fetch_grant(func, req)};
  endtask

  // Drops valid and waits until every predicted grant has been seen.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_THREAD_COUNT) cfg_threads = data;
    else cfg_policy = data[1:0];
  endtask

  task automatic send_random();
    fetch_req_t  req;
    logic [1:0]  func;
    int          roll, i;
    roll = $urandom_range(99);
    if (roll < 74) func = FUNC_SELECT;
    else if (roll < 86) func = FUNC_REMOVE;
    else if (roll < 98) func = FUNC_APPEND;
    else func = FUNC_UNUSED;
    req.tid = 2'($urandom_range(3));
    req.active = ($urandom_range(9) == 0) ? 4'b0000 : 4'($urandom_range(15));
    req.elig = 4'($urandom_range(15));
    // Small counts half the time so that ties come up often.
    for (i = 0; i < 4; i++)
      req.occ[i] = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    req.drain = ($urandom_range(4) == 0);
    req.status = 2'($urandom_range(3));
    req.cache = 3'($urandom_range(7));
    send_beat(func, req);
  endtask

  task automatic test_single_thread();
    quiesce();
    write_reg(REG_THREAD_COUNT, 3'd1);
    write_reg(REG_POLICY, {1'b0, POL_LSQ});
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0001, 4'b0001, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_SELECT, make_req(2'd3, 4'b1000, 4'b1111, 32'hFFFF_FFFF, 1'b1,
                                    ST_TRAP, CS_FAILED));
    // The lowest active thread is not eligible, so nobody fetches.
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b1111, 4'b1110, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0000, 4'b1111, 32'h0, 1'b1,
                                    ST_BLOCKED, CS_WAIT_RSP));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0000, 4'b1111, 32'h0, 1'b0, ST_BLOCKED, 3'd0));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0110, 4'b1001, 32'h0, 1'b0,
                                    ST_BLOCKED, CS_WAIT_RSP));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0110, 4'b1001, 32'h0, 1'b0,
                                    ST_SQUASH, CS_TLB_WAIT));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0110, 4'b1001, 32'h0, 1'b0,
                                    ST_TRAP, CS_WAIT_RSP));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0110, 4'b1001, 32'h0, 1'b0,
                                    ST_TRAP, CS_TLB_WAIT));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0110, 4'b1001, 32'h0, 1'b0, ST_TRAP, 3'd0));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0110, 4'b1001, 32'h0, 1'b0, 2'd0, CS_RETRY));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0110, 4'b1001, 32'h0, 1'b0, 2'd0, CS_FAILED));
    // Cache codes above access failed fall through to the unexpected cause.
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0110, 4'b1001, 32'h0, 1'b0, 2'd0, 3'd7));
    send_beat(FUNC_UNUSED, make_req(2'd1, 4'b1111, 4'b1111, 32'h0, 1'b1, ST_BLOCKED, 3'd0));
  endtask

  task automatic test_order_edits();
    quiesce();
    write_reg(REG_THREAD_COUNT, 3'd4);
    write_reg(REG_POLICY, {1'b0, POL_RR});
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b1111, 4'b1111, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_APPEND, make_req(2'd2, 4'b0000, 4'b0000, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_APPEND, make_req(2'd0, 4'b0000, 4'b0000, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_APPEND, make_req(2'd2, 4'b0000, 4'b0000, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_APPEND, make_req(2'd1, 4'b0000, 4'b0000, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_APPEND, make_req(2'd3, 4'b0000, 4'b0000, 32'h0, 1'b0, 2'd0, 3'd0));
    // The order is full here.
    send_beat(FUNC_APPEND, make_req(2'd1, 4'b0000, 4'b0000, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0000, 4'b1111, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0000, 4'b0001, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_REMOVE, make_req(2'd1, 4'b0000, 4'b0000, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_REMOVE, make_req(2'd1, 4'b0000, 4'b0000, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b1111, 4'b0000, 32'h0, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b0000, 4'b1111, 32'h0, 1'b0, 2'd0, 3'd0));
  endtask

  task automatic test_count_policies();
    quiesce();
    write_reg(REG_THREAD_COUNT, 3'd2);
    write_reg(REG_POLICY, {1'b0, POL_IQ});
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b1111, 4'b1111, 32'h0505_0505, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b1111, 4'b1111, 32'h00FF_FFFF, 1'b0, 2'd0, 3'd0));
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b1010, 4'b0111, 32'h0000_FF00, 1'b0, 2'd0, 3'd0));
    quiesce();
    write_reg(REG_POLICY, {1'b0, POL_LSQ});
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b1111, 4'b1111, 32'h0101_0209, 1'b0, 2'd0, 3'd0));
    quiesce();
    write_reg(REG_POLICY, {1'b0, POL_NONE});
    send_beat(FUNC_SELECT, make_req(2'd0, 4'b1111, 4'b1111, 32'h0, 1'b0, 2'd0, 3'd0));
  endtask

  task automatic test_random_traffic();
    int         p, n;
    logic [2:0] tc;
    logic [1:0] pol;
    for (p = 0; p < 10; p++) begin
      case (p)
        0: begin tc = 3'd1; pol = POL_RR;   end
        1: begin tc = 3'd4; pol = POL_RR;   end
        2: begin tc = 3'd2; pol = POL_IQ;   end
        3: begin tc = 3'd4; pol = POL_LSQ;  end
        4: begin tc = 3'd3; pol = POL_NONE; end
        5: begin tc = 3'd4; pol = POL_RR;   end
        6: begin tc = 3'd0; pol = POL_IQ;   end
        7: begin tc = 3'd7; pol = POL_RR;   end
        8: begin tc = 3'd4; pol = POL_IQ;   end
        default: begin tc = 3'd1; pol = POL_LSQ; end
      endcase
      quiesce();
      write_reg(REG_THREAD_COUNT, tc);
      // The unused top bit of the policy write is set at random.
      write_reg(REG_POLICY, {1'($urandom_range(1)), pol});
      src_idle_on = (p != 3);
      snk_idle_on = (p != 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) quiesce();
        send_random();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !(snk_idle_on && $urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_grant = m_tdata;
      if (pending_grants.size() == 0) begin
        $display("%0t: result beat with no grant expected: expected none, actual %h",
                 $time, m_tdata);
        mismatch_count++;
      end else begin
        want_grant = pending_grants.pop_front();
        check_field("grant_valid", want_grant.valid, seen_grant.valid);
        check_field("grant_thread", want_grant.thread, seen_grant.thread);
        check_field("stall_reason", want_grant.stall, seen_grant.stall);
        check_field("pad bit", 0, seen_grant.pad);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_smt_fetch_thread_arbiter_core: FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) rr_order[i] = 2'(i);
    rr_len = 0;
    cfg_threads = 3'd1;
    cfg_policy = POL_RR;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_single_thread();
    test_order_edits();
    test_count_policies();
    test_random_traffic();
    quiesce();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_smt_fetch_thread_arbiter_core: PASS");
    end else begin
      $display("tb_smt_fetch_thread_arbiter_core: FAIL");
    end
    $finish;
  end

endmodule
